// ===== rtl/retransmission_send_buffer_defines.svh =====
// Assertion helpers included by the RTL.
`ifndef RETRANSMISSION_SEND_BUFFER_DEFINES_SVH
`define RETRANSMISSION_SEND_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsb assertion failed");

`endif

// ===== rtl/rsb_pkg.sv =====
package rsb_pkg;

  localparam int DEF_CONNECTIONS  = 2;
  localparam int DEF_BUFFER_DEPTH = 16;

  localparam int SEQ_W  = 32;
  localparam int TYPE_W = 3;
  localparam int PAY_W  = 16;
  localparam int CNT_W  = 5;
  localparam int ST_W   = 3;

  // operation codes
  localparam logic [2:0] K_CLEAR  = 3'd0;
  localparam logic [2:0] K_ADD    = 3'd1;
  localparam logic [2:0] K_READ   = 3'd2;
  localparam logic [2:0] K_PREP   = 3'd3;
  localparam logic [2:0] K_QUERY  = 3'd4;
  localparam logic [2:0] K_REMOVE = 3'd5;
  localparam logic [2:0] K_STATUS = 3'd6;

  // message types
  localparam logic [TYPE_W-1:0] T_DATA     = 3'd0;
  localparam logic [TYPE_W-1:0] T_RETRDATA = 3'd1;
  localparam logic [TYPE_W-1:0] T_HB       = 3'd2;
  localparam logic [TYPE_W-1:0] T_RETRREQ  = 3'd3;
  localparam logic [TYPE_W-1:0] T_RETRRESP = 3'd4;

  // result status
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_SEQ      = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_CONN     = 3'd4;
  localparam logic [ST_W-1:0] ST_INTERNAL = 3'd5;

  // configuration register index
  localparam logic REG_ACTIVE = 1'b0;

  typedef struct packed {
    logic [PAY_W-1:0]  pay;
    logic [TYPE_W-1:0] typ;
    logic [SEQ_W-1:0]  seq;
  } desc_t;

endpackage

// ===== rtl/rsb_in_if.sv =====
interface rsb_in_if import rsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic              connection;
  logic [SEQ_W-1:0]  seq_number;
  logic [TYPE_W-1:0] msg_type;
  logic [PAY_W-1:0]  payload_handle;
  logic [SEQ_W-1:0]  new_start_seq;

  modport source (output valid, kind, connection, seq_number, msg_type, payload_handle,
                  new_start_seq, input ready);
  modport sink (input valid, kind, connection, seq_number, msg_type, payload_handle,
                new_start_seq, output ready);
endinterface

// ===== rtl/rsb_out_if.sv =====
interface rsb_out_if import rsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [TYPE_W-1:0] out_type;
  logic [SEQ_W-1:0]  out_seq;
  logic [PAY_W-1:0]  out_payload;
  logic [SEQ_W-1:0]  next_sequence;
  logic [CNT_W-1:0]  used_entries;
  logic [CNT_W-1:0]  free_entries;
  logic [CNT_W-1:0]  unsent_entries;

  modport source (output valid, status, out_type, out_seq, out_payload, next_sequence,
                  used_entries, free_entries, unsent_entries, input ready);
  modport sink (input valid, status, out_type, out_seq, out_payload, next_sequence,
                used_entries, free_entries, unsent_entries, output ready);
endinterface

// ===== rtl/rsb_cfg.sv =====
module rsb_cfg import rsb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [1:0]  active_conn
);

  logic [1:0] active_r, active_nxt;

  always_comb begin
    active_nxt = active_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_ACTIVE) begin
      active_nxt = cfg_pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 2'd1;
    end else begin
      active_r <= active_nxt;
    end
  end

  assign cfg_prdata  = (cfg_paddr[2] == REG_ACTIVE) ? {30'd0, active_r} : 32'd0;
  assign cfg_pready  = 1'b1;
  assign active_conn = active_r;

endmodule

// ===== rtl/retransmission_send_buffer.sv =====
// Query, remove and prepare walk the stored entries one by one; prepare then copies the
// rebuilt entries back (one entry memory read port and one scratch memory port, each with
// a registered read).
// Flow: one item at a time; the next item is taken once the result is registered.
// Reset: synchronous, active low; all ring pointers and counts clear, config reads 1.
module retransmission_send_buffer import rsb_pkg::*; #(
  parameter int CONNECTIONS  = DEF_CONNECTIONS,
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  rsb_in_if.sink      in_ch,
  rsb_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  `include "retransmission_send_buffer_defines.svh"

  localparam int SW = $clog2(BUFFER_DEPTH);
  localparam int NW = $clog2(BUFFER_DEPTH + 1);
  localparam int CW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int NC = 1 << CW;
  localparam int AW = (CONNECTIONS * BUFFER_DEPTH > 1) ?
                      $clog2(CONNECTIONS * BUFFER_DEPTH) : 1;
  localparam int ED = CONNECTIONS * BUFFER_DEPTH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_RDW  = 4'd2;
  localparam logic [3:0] S_WRD  = 4'd3;
  localparam logic [3:0] S_WEV  = 4'd4;
  localparam logic [3:0] S_PRR  = 4'd5;
  localparam logic [3:0] S_PEND = 4'd6;
  localparam logic [3:0] S_CRD  = 4'd7;
  localparam logic [3:0] S_CWR  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  function automatic logic [SW-1:0] wrap(input logic [SW-1:0] p, input logic [NW-1:0] k);
    logic [NW:0] s;
    s = (NW+1)'(p) + (NW+1)'(k);
    if (s >= (NW+1)'(BUFFER_DEPTH)) s = s - (NW+1)'(BUFFER_DEPTH);
    return s[SW-1:0];
  endfunction

  function automatic logic [AW-1:0] eaddr(input logic [CW-1:0] c, input logic [NW-1:0] s);
    return AW'(int'(c) * BUFFER_DEPTH + int'(s));
  endfunction

  function automatic logic [CNT_W-1:0] fit5(input logic [NW-1:0] v);
    logic [NW+CNT_W-1:0] t;
    t = {{CNT_W{1'b0}}, v};
    return t[CNT_W-1:0];
  endfunction

  logic [1:0] active_conn;

  rsb_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .active_conn (active_conn)
  );

  // control state
  logic [3:0]    state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] rp_r [NC], rp_nxt [NC];
  logic [SW-1:0] wp_r [NC], wp_nxt [NC];
  logic [SW-1:0] mp_r [NC], mp_nxt [NC];
  logic [NW-1:0] used_r [NC], used_nxt [NC];
  logic [NW-1:0] unsent_r [NC], unsent_nxt [NC];

  // item and working registers
  logic [2:0]        kind_r, kind_nxt;
  logic              conn_r, conn_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [TYPE_W-1:0] mtype_r, mtype_nxt;
  logic [PAY_W-1:0]  pay_r, pay_nxt;
  logic [SEQ_W-1:0]  start_r, start_nxt;
  logic [NW-1:0]     i_r, i_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [SEQ_W-1:0]  cur_r, cur_nxt;
  logic [SEQ_W-1:0]  exp_r, exp_nxt;
  logic              ended_r, ended_nxt;
  logic              bad_r, bad_nxt;
  logic [ST_W-1:0]   rst_r, rst_nxt;
  desc_t             rdesc_r, rdesc_nxt;
  logic [SEQ_W-1:0]  rnext_r, rnext_nxt;

  logic [ST_W-1:0]   o_status_r, o_status_nxt;
  desc_t             o_desc_r, o_desc_nxt;
  logic [SEQ_W-1:0]  o_next_r, o_next_nxt;
  logic [CNT_W-1:0]  o_used_r, o_used_nxt;
  logic [CNT_W-1:0]  o_free_r, o_free_nxt;
  logic [CNT_W-1:0]  o_unsent_r, o_unsent_nxt;

  // entry memory and rebuild scratch memory
  desc_t         ent_mem [ED];
  desc_t         ent_q;
  logic          ent_we;
  logic [AW-1:0] ent_wa, ent_ra;
  desc_t         ent_wd;
  desc_t         reb_mem [BUFFER_DEPTH];
  desc_t         reb_q;
  logic          reb_we;
  logic [SW-1:0] reb_wa, reb_ra;
  desc_t         reb_wd;

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_q <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (reb_we) reb_mem[reb_wa] <= reb_wd;
    reb_q <= reb_mem[reb_ra];
  end

  logic [CW-1:0] cidx;
  logic [NW-1:0] used_c, unsent_c;
  logic          sent_c;
  logic [SEQ_W-1:0] exp1;

  assign cidx     = CW'(conn_r);
  assign used_c   = used_r[cidx];
  assign unsent_c = unsent_r[cidx];
  assign sent_c   = i_r < (used_c - unsent_c);
  assign exp1     = exp_r + 32'd1;

  always_comb begin
    logic full;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rp_nxt = rp_r;
    wp_nxt = wp_r;
    mp_nxt = mp_r;
    used_nxt = used_r;
    unsent_nxt = unsent_r;
    kind_nxt = kind_r;
    conn_nxt = conn_r;
    seq_nxt = seq_r;
    mtype_nxt = mtype_r;
    pay_nxt = pay_r;
    start_nxt = start_r;
    i_nxt = i_r;
    n_nxt = n_r;
    cur_nxt = cur_r;
    exp_nxt = exp_r;
    ended_nxt = ended_r;
    bad_nxt = bad_r;
    rst_nxt = rst_r;
    rdesc_nxt = rdesc_r;
    rnext_nxt = rnext_r;
    o_status_nxt = o_status_r;
    o_desc_nxt = o_desc_r;
    o_next_nxt = o_next_r;
    o_used_nxt = o_used_r;
    o_free_nxt = o_free_r;
    o_unsent_nxt = o_unsent_r;
    ent_we = 1'b0;
    ent_wa = eaddr(cidx, {NW{1'b0}});
    ent_wd = '0;
    ent_ra = eaddr(cidx, {NW{1'b0}});
    reb_we = 1'b0;
    reb_wa = n_r[SW-1:0];
    reb_wd = '0;
    reb_ra = i_r[SW-1:0];
    full   = n_r >= NW'(BUFFER_DEPTH);

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          conn_nxt  = in_ch.connection;
          seq_nxt   = in_ch.seq_number;
          mtype_nxt = in_ch.msg_type;
          pay_nxt   = in_ch.payload_handle;
          start_nxt = in_ch.new_start_seq;
          rst_nxt   = ST_OK;
          rdesc_nxt = '0;
          rnext_nxt = '0;
          bad_nxt   = ({1'b0, in_ch.connection} >= active_conn) ||
                      (int'(in_ch.connection) >= CONNECTIONS);
          if (bad_nxt) begin
            rst_nxt   = ST_CONN;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        i_nxt = '0;
        case (kind_r)
          K_CLEAR: begin
            rp_nxt[cidx] = '0;
            wp_nxt[cidx] = '0;
            mp_nxt[cidx] = '0;
            used_nxt[cidx] = '0;
            unsent_nxt[cidx] = '0;
          end
          K_ADD: begin
            if (used_c >= NW'(BUFFER_DEPTH)) begin
              rst_nxt = ST_FULL;
            end else begin
              ent_we = 1'b1;
              ent_wa = eaddr(cidx, NW'(wp_r[cidx]));
              ent_wd.seq = seq_r;
              ent_wd.typ = mtype_r;
              ent_wd.pay = (mtype_r == T_HB || mtype_r == T_RETRREQ ||
                            mtype_r == T_RETRRESP) ? '0 : pay_r;
              wp_nxt[cidx] = wrap(wp_r[cidx], NW'(1));
              used_nxt[cidx] = used_c + NW'(1);
              unsent_nxt[cidx] = unsent_c + NW'(1);
            end
          end
          K_READ: begin
            if (unsent_c == '0) begin
              rst_nxt = ST_EMPTY;
            end else begin
              ent_ra = eaddr(cidx, NW'(rp_r[cidx]));
              state_nxt = S_RDW;
            end
          end
          K_PREP: begin
            if (used_c == '0) begin
              rst_nxt = ST_SEQ;
            end else begin
              // open the rebuild with the retransmission response
              reb_we = 1'b1;
              reb_wa = '0;
              reb_wd.seq = start_r;
              reb_wd.typ = T_RETRRESP;
              n_nxt = NW'(1);
              cur_nxt = start_r + 32'd1;
              exp_nxt = seq_r;
              ended_nxt = 1'b0;
              state_nxt = S_WRD;
            end
          end
          K_QUERY, K_REMOVE: state_nxt = S_WRD;
          default: ;
        endcase
      end
      S_RDW: begin
        rdesc_nxt = ent_q;
        rp_nxt[cidx] = wrap(rp_r[cidx], NW'(1));
        unsent_nxt[cidx] = unsent_c - NW'(1);
        state_nxt = S_OUT;
      end
      S_WRD: begin
        ent_ra = eaddr(cidx, NW'(wrap(mp_r[cidx], i_r)));
        state_nxt = S_WEV;
        if (kind_r == K_REMOVE) begin
          if (used_c <= unsent_c) state_nxt = S_OUT;
        end else if (i_r >= used_c) begin
          if (kind_r == K_QUERY) begin
            rst_nxt = ST_SEQ;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_PEND;
          end
        end
      end
      S_WEV: begin
        state_nxt = S_WRD;
        if (kind_r == K_REMOVE) begin
          if ((seq_r - ent_q.seq) >= SEQ_W'(BUFFER_DEPTH)) begin
            state_nxt = S_OUT;
          end else begin
            used_nxt[cidx] = used_c - NW'(1);
            mp_nxt[cidx] = wrap(mp_r[cidx], NW'(1));
            if (ent_q.seq == seq_r) state_nxt = S_OUT;
          end
        end else if (kind_r == K_QUERY) begin
          i_nxt = i_r + NW'(1);
          if (ent_q.seq == seq_r) state_nxt = S_OUT;
        end else begin
          i_nxt = i_r + NW'(1);
          exp_nxt = exp1;
          reb_wd.seq = cur_r;
          reb_wd.typ = ent_q.typ;
          reb_wd.pay = ent_q.pay;
          if (ent_q.seq != exp1) begin
            rst_nxt = ST_SEQ;
            state_nxt = S_OUT;
          end else if (sent_c) begin
            if (ent_q.typ == T_DATA || ent_q.typ == T_RETRDATA) begin
              reb_wd.typ = T_RETRDATA;
              reb_we = !full;
            end
          end else begin
            case (ent_q.typ)
              T_RETRDATA: begin
                if (ended_r) begin
                  rst_nxt = ST_INTERNAL;
                  state_nxt = S_OUT;
                end else begin
                  reb_we = !full;
                end
              end
              T_DATA: begin
                ended_nxt = 1'b1;
                reb_we = !full;
              end
              T_RETRREQ: begin
                reb_wd.pay = '0;
                reb_we = !full;
                if (!ended_r) begin
                  // heartbeat closes the retransmitted part, request follows
                  reb_wd.typ = T_HB;
                  ended_nxt = 1'b1;
                  if (!full) state_nxt = S_PRR;
                end
              end
              T_HB: ;
              default: begin
                rst_nxt = ST_INTERNAL;
                state_nxt = S_OUT;
              end
            endcase
            if (ent_q.typ == T_DATA || ent_q.typ == T_RETRDATA ||
                ent_q.typ == T_RETRREQ) begin
              if (full && !(ent_q.typ == T_RETRDATA && ended_r)) begin
                rst_nxt = ST_FULL;
                state_nxt = S_OUT;
              end
            end
          end
          if (sent_c && ent_q.seq == exp1 && full &&
              (ent_q.typ == T_DATA || ent_q.typ == T_RETRDATA)) begin
            rst_nxt = ST_FULL;
            state_nxt = S_OUT;
          end
          if (reb_we) begin
            n_nxt = n_r + NW'(1);
            cur_nxt = cur_r + 32'd1;
          end
        end
      end
      S_PRR: begin
        if (full) begin
          rst_nxt = ST_FULL;
          state_nxt = S_OUT;
        end else begin
          reb_we = 1'b1;
          reb_wd.seq = cur_r;
          reb_wd.typ = T_RETRREQ;
          n_nxt = n_r + NW'(1);
          cur_nxt = cur_r + 32'd1;
          state_nxt = S_WRD;
        end
      end
      S_PEND: begin
        i_nxt = '0;
        rnext_nxt = cur_r;
        state_nxt = S_CRD;
        if (!ended_r) begin
          reb_wd.seq = cur_r;
          reb_wd.typ = T_HB;
          reb_we = !full;
          n_nxt = n_r + NW'(1);
          cur_nxt = cur_r + 32'd1;
          rnext_nxt = cur_r + 32'd1;
        end
        if (!ended_r && full) begin
          rst_nxt = ST_FULL;
          state_nxt = S_OUT;
        end else if (used_c >= NW'(BUFFER_DEPTH)) begin
          rst_nxt = ST_INTERNAL;
          state_nxt = S_OUT;
        end
      end
      S_CRD: begin
        if (i_r >= n_r) begin
          rp_nxt[cidx] = '0;
          mp_nxt[cidx] = '0;
          wp_nxt[cidx] = (n_r == NW'(BUFFER_DEPTH)) ? '0 : n_r[SW-1:0];
          used_nxt[cidx] = n_r;
          unsent_nxt[cidx] = n_r;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CWR;
        end
      end
      S_CWR: begin
        ent_we = 1'b1;
        ent_wa = eaddr(cidx, i_r);
        ent_wd = reb_q;
        i_nxt = i_r + NW'(1);
        state_nxt = S_CRD;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt = rst_r;
          o_desc_nxt = rdesc_r;
          o_next_nxt = (rst_r == ST_OK && kind_r == K_PREP) ? rnext_r : '0;
          if (bad_r) begin
            o_used_nxt = '0;
            o_free_nxt = '0;
            o_unsent_nxt = '0;
          end else begin
            o_used_nxt = fit5(used_c);
            o_free_nxt = fit5(NW'(BUFFER_DEPTH) - used_c);
            o_unsent_nxt = fit5(unsent_c);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        rp_r[c] <= '0;
        wp_r[c] <= '0;
        mp_r[c] <= '0;
        used_r[c] <= '0;
        unsent_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rp_r <= rp_nxt;
      wp_r <= wp_nxt;
      mp_r <= mp_nxt;
      used_r <= used_nxt;
      unsent_r <= unsent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    conn_r <= conn_nxt;
    seq_r <= seq_nxt;
    mtype_r <= mtype_nxt;
    pay_r <= pay_nxt;
    start_r <= start_nxt;
    i_r <= i_nxt;
    n_r <= n_nxt;
    cur_r <= cur_nxt;
    exp_r <= exp_nxt;
    ended_r <= ended_nxt;
    bad_r <= bad_nxt;
    rst_r <= rst_nxt;
    rdesc_r <= rdesc_nxt;
    rnext_r <= rnext_nxt;
    o_status_r <= o_status_nxt;
    o_desc_r <= o_desc_nxt;
    o_next_r <= o_next_nxt;
    o_used_r <= o_used_nxt;
    o_free_r <= o_free_nxt;
    o_unsent_r <= o_unsent_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = o_status_r;
  assign out_ch.out_type      = o_desc_r.typ;
  assign out_ch.out_seq       = o_desc_r.seq;
  assign out_ch.out_payload   = o_desc_r.pay;
  assign out_ch.next_sequence = o_next_r;
  assign out_ch.used_entries  = o_used_r;
  assign out_ch.free_entries  = o_free_r;
  assign out_ch.unsent_entries = o_unsent_r;

  `RSB_ASSERT_IMP(a_unsent_le_used, clk, rst_n, state_r != S_IDLE, unsent_c <= used_c)
  `RSB_ASSERT_IMP(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_OUT)
  `RSB_ASSERT_IMP(a_walk_bound, clk, rst_n, state_r == S_WEV && kind_r != K_REMOVE, i_r < used_c)

endmodule

// ===== sim/retransmission_send_buffer_test.sv =====
`timescale 1ns / 100ps

module retransmission_send_buffer_test;
  import rsb_pkg::*;

  localparam int RING_DEPTH = DEF_BUFFER_DEPTH;
  localparam int RING_COUNT = DEF_CONNECTIONS;
  localparam logic [2:0] K_SPARE = 3'd7;
  localparam logic [TYPE_W-1:0] T_OTHER = 3'd5;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [2:0]        kind;
    logic              conn;
    logic [SEQ_W-1:0]  seq;
    logic [TYPE_W-1:0] mtype;
    logic [PAY_W-1:0]  pay;
    logic [SEQ_W-1:0]  start;
  } op_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [TYPE_W-1:0] otype;
    logic [SEQ_W-1:0]  oseq;
    logic [PAY_W-1:0]  opay;
    logic [SEQ_W-1:0]  next;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
    logic [CNT_W-1:0]  unsent;
  } answer_t;

  class ring_scoreboard;
    logic [SEQ_W-1:0]  seq_mem [RING_COUNT][RING_DEPTH];
    logic [TYPE_W-1:0] type_mem [RING_COUNT][RING_DEPTH];
    logic [PAY_W-1:0]  pay_mem [RING_COUNT][RING_DEPTH];
    bit                sent_mem [RING_COUNT][RING_DEPTH];
    int                rd_ptr [RING_COUNT];
    int                wr_ptr [RING_COUNT];
    int                rm_ptr [RING_COUNT];
    int                used [RING_COUNT];
    int                unsent [RING_COUNT];
    logic [SEQ_W-1:0]  resume_seq [RING_COUNT];
    int                active;
    answer_t           pending_answers [$];
    int                errors;
    int                checked;
    int                rebuilds_ok;

    function new();
      for (int c = 0; c < RING_COUNT; c++) begin
        for (int i = 0; i < RING_DEPTH; i++) begin
          seq_mem[c][i] = '0;
          type_mem[c][i] = '0;
          pay_mem[c][i] = '0;
        end
        wipe(c);
        resume_seq[c] = '0;
      end
      active = 1;
      errors = 0;
      checked = 0;
      rebuilds_ok = 0;
    endfunction

    function void wipe(int c);
      rd_ptr[c] = 0;
      wr_ptr[c] = 0;
      rm_ptr[c] = 0;
      used[c] = 0;
      unsent[c] = 0;
      for (int i = 0; i < RING_DEPTH; i++) sent_mem[c][i] = 0;
    endfunction

    function logic [ST_W-1:0] rebuild(int c, logic [SEQ_W-1:0] last,
                                      logic [SEQ_W-1:0] start, output logic [SEQ_W-1:0] next);
      desc_t staged [$];
      logic [SEQ_W-1:0] cur;
      logic [SEQ_W-1:0] want;
      logic [TYPE_W-1:0] t;
      bit ended;
      int slot;
      cur = start;
      want = last;
      ended = 0;
      next = '0;
      if (used[c] == 0) return ST_SEQ;
      staged.push_back('{pay: '0, typ: T_RETRRESP, seq: cur});
      cur++;
      for (int i = 0; i < used[c]; i++) begin
        slot = (rm_ptr[c] + i) % RING_DEPTH;
        t = type_mem[c][slot];
        want++;
        if (seq_mem[c][slot] != want) return ST_SEQ;
        if (sent_mem[c][slot]) begin
          if (t == T_DATA || t == T_RETRDATA) begin
            if (staged.size() >= RING_DEPTH) return ST_FULL;
            staged.push_back('{pay: pay_mem[c][slot], typ: T_RETRDATA, seq: cur});
            cur++;
          end
        end else if (t == T_RETRDATA) begin
          if (ended) return ST_INTERNAL;
          if (staged.size() >= RING_DEPTH) return ST_FULL;
          staged.push_back('{pay: pay_mem[c][slot], typ: T_RETRDATA, seq: cur});
          cur++;
        end else if (t == T_DATA) begin
          ended = 1;
          if (staged.size() >= RING_DEPTH) return ST_FULL;
          staged.push_back('{pay: pay_mem[c][slot], typ: T_DATA, seq: cur});
          cur++;
        end else if (t == T_RETRREQ) begin
          if (!ended) begin
            if (staged.size() >= RING_DEPTH) return ST_FULL;
            staged.push_back('{pay: '0, typ: T_HB, seq: cur});
            cur++;
            ended = 1;
          end
          if (staged.size() >= RING_DEPTH) return ST_FULL;
          staged.push_back('{pay: '0, typ: T_RETRREQ, seq: cur});
          cur++;
        end else if (t != T_HB) begin
          return ST_INTERNAL;
        end
      end
      if (!ended) begin
        if (staged.size() >= RING_DEPTH) return ST_FULL;
        staged.push_back('{pay: '0, typ: T_HB, seq: cur});
        cur++;
      end
      if (used[c] >= RING_DEPTH) return ST_INTERNAL;
      wipe(c);
      foreach (staged[i]) begin
        seq_mem[c][i] = staged[i].seq;
        type_mem[c][i] = staged[i].typ;
        pay_mem[c][i] = staged[i].pay;
      end
      used[c] = staged.size();
      unsent[c] = staged.size();
      wr_ptr[c] = staged.size() % RING_DEPTH;
      next = cur;
      return ST_OK;
    endfunction

    // Advance the ring copy by one accepted item and queue its answer.
    function void note_item(op_t op);
      answer_t a;
      int c;
      int slot;
      logic [SEQ_W-1:0] es;
      a = '0;
      c = op.conn;
      if (c >= active || c >= RING_COUNT) begin
        a.status = ST_CONN;
        pending_answers.push_back(a);
        return;
      end
      a.status = ST_OK;
      case (op.kind)
        K_CLEAR: wipe(c);
        K_ADD: begin
          if (used[c] >= RING_DEPTH) begin
            a.status = ST_FULL;
          end else begin
            slot = wr_ptr[c];
            seq_mem[c][slot] = op.seq;
            type_mem[c][slot] = op.mtype;
            pay_mem[c][slot] = (op.mtype == T_HB || op.mtype == T_RETRREQ ||
                                op.mtype == T_RETRRESP) ? '0 : op.pay;
            sent_mem[c][slot] = 0;
            used[c]++;
            unsent[c]++;
            wr_ptr[c] = (wr_ptr[c] + 1) % RING_DEPTH;
          end
        end
        K_READ: begin
          if (unsent[c] == 0) begin
            a.status = ST_EMPTY;
          end else begin
            slot = rd_ptr[c];
            a.otype = type_mem[c][slot];
            a.oseq = seq_mem[c][slot];
            a.opay = pay_mem[c][slot];
            sent_mem[c][slot] = 1;
            rd_ptr[c] = (rd_ptr[c] + 1) % RING_DEPTH;
            unsent[c]--;
          end
        end
        K_PREP: begin
          a.status = rebuild(c, op.seq, op.start, a.next);
          if (a.status == ST_OK) begin
            resume_seq[c] = a.next;
            rebuilds_ok++;
          end else begin
            a.next = '0;
          end
        end
        K_QUERY: begin
          a.status = ST_SEQ;
          for (int i = 0; i < used[c]; i++)
            if (seq_mem[c][(rm_ptr[c] + i) % RING_DEPTH] == op.seq) a.status = ST_OK;
        end
        K_REMOVE: begin
          while (used[c] > unsent[c]) begin
            slot = rm_ptr[c];
            es = seq_mem[c][slot];
            if (SEQ_W'(op.seq - es) >= RING_DEPTH) break;
            sent_mem[c][slot] = 0;
            used[c]--;
            rm_ptr[c] = (rm_ptr[c] + 1) % RING_DEPTH;
            if (es == op.seq) break;
          end
        end
        default: ;
      endcase
      a.used = CNT_W'(used[c]);
      a.free = CNT_W'(RING_DEPTH - used[c]);
      a.unsent = CNT_W'(unsent[c]);
      pending_answers.push_back(a);
    endfunction

    task mismatch(string what, logic [SEQ_W-1:0] got, logic [SEQ_W-1:0] want);
      $display("%0t: result %0d %s is 0x%0h, want 0x%0h", $realtime, checked, what, got, want);
      errors++;
    endtask

    task check_result(answer_t got);
      answer_t w;
      if (pending_answers.size() == 0) begin
        $display("%0t: result with no item waiting for it", $realtime);
        errors++;
        return;
      end
      w = pending_answers.pop_front();
      if (got.status !== w.status) mismatch("status", got.status, w.status);
      if (got.otype !== w.otype) mismatch("out_type", got.otype, w.otype);
      if (got.oseq !== w.oseq) mismatch("out_seq", got.oseq, w.oseq);
      if (got.opay !== w.opay) mismatch("out_payload", got.opay, w.opay);
      if (got.next !== w.next) mismatch("next_sequence", got.next, w.next);
      if (got.used !== w.used) mismatch("used_entries", got.used, w.used);
      if (got.free !== w.free) mismatch("free_entries", got.free, w.free);
      if (got.unsent !== w.unsent) mismatch("unsent_entries", got.unsent, w.unsent);
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rsb_in_if  in_ch ();
  rsb_out_if out_ch ();

  retransmission_send_buffer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  ring_scoreboard sb = new();
  bit send_idle;
  bit recv_stall;
  int idle_pct;
  int hold_left;
  logic [SEQ_W-1:0] seq_next [RING_COUNT];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls, or a long counted hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(recv_stall && $urandom_range(0, 99) < idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{status: out_ch.status, otype: out_ch.out_type, oseq: out_ch.out_seq,
                        opay: out_ch.out_payload, next: out_ch.next_sequence,
                        used: out_ch.used_entries, free: out_ch.free_entries,
                        unsent: out_ch.unsent_entries});
  end

  task send_item(op_t op);
    int gap;
    gap = 0;
    while (send_idle && gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= op.kind;
    in_ch.connection <= op.conn;
    in_ch.seq_number <= op.seq;
    in_ch.msg_type <= op.mtype;
    in_ch.payload_handle <= op.pay;
    in_ch.new_start_seq <= op.start;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    sb.note_item(op);
  endtask

  task drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (sb.pending_answers.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_active(logic [1:0] value);
    drain();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_ACTIVE, 2'b00};
    cfg_pwdata <= {30'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.active = value;
  endtask

  function op_t make_op(logic [2:0] kind, logic conn, logic [SEQ_W-1:0] seq,
                        logic [TYPE_W-1:0] mtype, logic [PAY_W-1:0] pay,
                        logic [SEQ_W-1:0] start);
    op_t op;
    op.kind = kind;
    op.conn = conn;
    op.seq = seq;
    op.mtype = mtype;
    op.pay = pay;
    op.start = start;
    return op;
  endfunction

  // Mostly well-formed traffic on a live ring, with some raw noise.
  function op_t pick_op();
    op_t op;
    int c;
    int r;
    int oldest;
    op = '{kind: K_STATUS, conn: 1'b0, seq: $urandom(), mtype: T_DATA,
           pay: PAY_W'($urandom()), start: $urandom()};
    c = (sb.active > 1) ? $urandom_range(0, 1) : 0;
    op.conn = 1'(c);
    r = $urandom_range(0, 99);
    oldest = sb.rm_ptr[c];
    if (r < 36) begin
      op.kind = K_ADD;
      op.seq = seq_next[c];
      seq_next[c]++;
      case ($urandom_range(0, 19))
        0: op.mtype = T_RETRRESP;
        1: op.mtype = T_OTHER;
        2, 3, 4: op.mtype = T_HB;
        5, 6, 7: op.mtype = T_RETRREQ;
        8, 9, 10, 11: op.mtype = T_RETRDATA;
        default: op.mtype = T_DATA;
      endcase
    end else if (r < 58) begin
      op.kind = K_READ;
    end else if (r < 72) begin
      op.kind = K_REMOVE;
      op.seq = (sb.used[c] > 0) ? sb.seq_mem[c][oldest] + $urandom_range(0, 6)
                                : seq_next[c] - 1;
    end else if (r < 80) begin
      op.kind = K_QUERY;
      op.seq = seq_next[c] - $urandom_range(0, 20);
    end else if (r < 90) begin
      op.kind = K_PREP;
      if (sb.used[c] > 0 && $urandom_range(0, 4) != 0)
        op.seq = sb.seq_mem[c][oldest] - 1;
    end else if (r < 92) begin
      op.kind = K_CLEAR;
    end else if (r < 94) begin
      op.kind = K_STATUS;
    end else begin
      op.kind = 3'($urandom_range(0, 7));
      op.conn = 1'($urandom_range(0, 1));
      op.mtype = TYPE_W'($urandom_range(0, 7));
    end
    return op;
  endfunction

  task after_item(op_t op);
    if (op.kind == K_PREP && sb.pending_answers.size() > 0 &&
        sb.pending_answers[$].status == ST_OK)
      seq_next[op.conn] = sb.resume_seq[op.conn];
  endtask

  initial begin
    op_t op;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = K_CLEAR;
    in_ch.connection = 1'b0;
    in_ch.seq_number = '0;
    in_ch.msg_type = T_DATA;
    in_ch.payload_handle = '0;
    in_ch.new_start_seq = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle = 0;
    recv_stall = 0;
    idle_pct = 87;
    hold_left = 0;
    seq_next[0] = 32'hFFFF_FFFE;
    seq_next[1] = 32'h0000_0100;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    send_item(make_op(K_PREP, 1'b0, 32'd5, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_STATUS, 1'b1, 32'd0, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_READ, 1'b0, 32'd0, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_ADD, 1'b0, 32'hFFFF_FFFE, T_DATA, 16'hFFFF, 32'd0));
    send_item(make_op(K_ADD, 1'b0, 32'hFFFF_FFFF, T_RETRDATA, 16'h1234, 32'd0));
    send_item(make_op(K_ADD, 1'b0, 32'h0000_0000, T_HB, 16'hFFFF, 32'd0));
    send_item(make_op(K_ADD, 1'b0, 32'h0000_0001, T_RETRREQ, 16'hAAAA, 32'd0));
    send_item(make_op(K_READ, 1'b0, 32'd0, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_READ, 1'b0, 32'd0, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_QUERY, 1'b0, 32'hFFFF_FFFF, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_QUERY, 1'b0, 32'h0000_0042, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_PREP, 1'b0, 32'h0000_0007, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_PREP, 1'b0, 32'hFFFF_FFFD, T_DATA, 16'h0, 32'hFFFF_FFFF));
    send_item(make_op(K_READ, 1'b0, 32'd0, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_READ, 1'b0, 32'd0, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_REMOVE, 1'b0, 32'hFFFF_FFFF, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_ADD, 1'b0, 32'h0000_0009, T_RETRRESP, 16'h5555, 32'd0));
    send_item(make_op(K_ADD, 1'b0, 32'h0000_000A, T_OTHER, 16'h00FF, 32'd0));
    send_item(make_op(K_PREP, 1'b0, 32'h0000_0000, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_SPARE, 1'b0, 32'd0, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_CLEAR, 1'b0, 32'd0, T_DATA, 16'h0, 32'd0));
    send_item(make_op(K_ADD, 1'b0, 32'h0000_0010, T_RETRDATA, 16'h0F0F, 32'd0));
    send_item(make_op(K_ADD, 1'b0, 32'h0000_0011, T_DATA, 16'hF0F0, 32'd0));
    send_item(make_op(K_PREP, 1'b0, 32'h0000_000F, T_DATA, 16'h0, 32'h8000_0000));
    seq_next[0] = sb.resume_seq[0];

    for (int phase = 0; phase < 4; phase++) begin
      write_active((phase % 2 == 0) ? 2'd2 : 2'd1);
      send_idle = (phase == 1 || phase == 3);
      recv_stall = (phase == 2 || phase == 3);
      idle_pct = (phase == 3) ? 31 : 87;
      if (phase == 0) hold_left = 300;
      for (int n = 0; n < 100; n++) begin
        if (phase == 2 && n == 50) begin
          @(negedge clk);
          in_ch.valid <= 1'b0;
          wait (sb.pending_answers.size() == 0);
        end
        op = pick_op();
        send_item(op);
        after_item(op);
      end
    end
    drain();

    $display("checked %0d results over 4 traffic phases, %0d successful rebuilds",
             sb.checked, sb.rebuilds_ok);
    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
